FILE: src/fbm_value_noise_height_defines.svh
// assertion macros for the fractal value-noise height block
`ifndef FBM_VALUE_NOISE_HEIGHT_DEFINES_SVH
`define FBM_VALUE_NOISE_HEIGHT_DEFINES_SVH

// clocked check, held off while reset is asserted
`define FBMVN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define FBMVN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fbmvn_pkg.sv
// shared types and constants for the fractal value-noise height block
`timescale 1ns / 1ps
package fbmvn_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FBM_W = 24;
	localparam int LAT_W = 48;

	localparam logic [31:0] HASH_X = 32'd374761393;
	localparam logic [31:0] HASH_Z = 32'd668265263;
	localparam logic [31:0] HASH_MIX = 32'd1274126177;
	localparam logic [31:0] VALUE_MASK = 32'h00FF_FFFF;

	localparam logic [2:0] CFG_SEED = 3'd0;
	localparam logic [2:0] CFG_OCTAVES = 3'd1;
	localparam logic [2:0] CFG_NSCALE = 3'd2;
	localparam logic [2:0] CFG_HSCALE = 3'd3;

	// lattice coordinates, Q32.16 in the low 48 bits
	typedef struct packed {
		logic [LAT_W-1:0] bx;
		logic [LAT_W-1:0] bz;
	} lat_t;

endpackage

FILE: src/fbmvn_octave_cell.sv
// one octave cell: corner hash, smoothstep, bilinear blend, horner accumulate
`timescale 1ns / 1ps
module fbmvn_octave_cell #(
	parameter int IDX = 0,
	parameter int CW = 4,
	parameter int SW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [31:0]       seed,
	input  logic [CW-1:0]     cnt,
	input  logic              vld_i,
	input  fbmvn_pkg::lat_t   lat_i,
	input  logic [SW-1:0]     acc_i,
	output logic              vld_o,
	output fbmvn_pkg::lat_t   lat_o,
	output logic [SW-1:0]     acc_o
);
	import fbmvn_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [LAT_W-1:0] xb, zb;
	logic [31:0] mx_s1, mz_s1, sqx_s1, sqz_s1;
	logic [15:0] tx_s1, tz_s1;
	lat_t lat_s1, lat_s2, lat_s3, lat_s4;
	logic [SW-1:0] acc_s1, acc_s2, acc_s3, acc_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [31:0] base;
	logic [31:0] n [4];
	logic [31:0] hm_s2 [4];
	logic [49:0] pux, puz;
	logic [15:0] u_s2, v_s2, v_s3;
	logic [23:0] val [4];
	logic [40:0] bab, bcd, be;
	logic [23:0] ab_s3, cd_s3;

	assign xb = lat_i.bx << IDX;
	assign zb = lat_i.bz << IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= xb[47:16] * HASH_X;
			mz_s1 <= zb[47:16] * HASH_Z;
			tx_s1 <= xb[15:0];
			tz_s1 <= zb[15:0];
			sqx_s1 <= xb[15:0] * xb[15:0];
			sqz_s1 <= zb[15:0] * zb[15:0];
			lat_s1 <= lat_i;
			acc_s1 <= acc_i;
		end
	end

	// corner sums share the two products, +1 on a lattice axis adds its constant
	always_comb begin
		base = mx_s1 + mz_s1 + seed + 32'(IDX);
		n[0] = base;
		n[1] = base + HASH_X;
		n[2] = base + HASH_Z;
		n[3] = base + HASH_X + HASH_Z;
		pux = sqx_s1 * (18'd196608 - {1'b0, tx_s1, 1'b0});
		puz = sqz_s1 * (18'd196608 - {1'b0, tz_s1, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				hm_s2[k] <= (n[k] ^ (n[k] >> 13)) * HASH_MIX;
			end
			u_s2 <= pux[47:32];
			v_s2 <= puz[47:32];
			lat_s2 <= lat_s1;
			acc_s2 <= acc_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			val[k] = 24'((hm_s2[k] ^ (hm_s2[k] >> 16)) & VALUE_MASK);
		end
		bab = 41'(val[0]) * (41'd65536 - 41'(u_s2)) + 41'(val[1]) * 41'(u_s2);
		bcd = 41'(val[2]) * (41'd65536 - 41'(u_s2)) + 41'(val[3]) * 41'(u_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s3 <= bab[39:16];
			cd_s3 <= bcd[39:16];
			v_s3 <= v_s2;
			lat_s3 <= lat_s2;
			acc_s3 <= acc_s2;
		end
	end

	assign be = 41'(ab_s3) * (41'd65536 - 41'(v_s3)) + 41'(cd_s3) * 41'(v_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			lat_s4 <= lat_s3;
			if (IDX_C < cnt) begin
				acc_s4 <= {acc_s3[SW-2:0], 1'b0} + SW'(be[39:16]);
			end else begin
				acc_s4 <= acc_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign vld_o = vld_s4;
	assign lat_o = lat_s4;
	assign acc_o = acc_s4;

endmodule

FILE: src/fbmvn_div_cell.sv
// one restoring division step by the octave weight total
`timescale 1ns / 1ps
module fbmvn_div_cell #(
	parameter int M = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [M-1:0] dvs,
	input  logic         vld_i,
	input  logic [M-1:0] rem_i,
	input  logic [23:0]  low_i,
	output logic         vld_o,
	output logic [M-1:0] rem_o,
	output logic [23:0]  low_o
);
	import fbmvn_pkg::*;

	logic [M:0] t;
	logic ge;
	logic [M:0] diff;
	logic [M-1:0] rem_s1;
	logic [23:0] low_s1;
	logic vld_s1;

	assign t = {rem_i, low_i[23]};
	assign ge = t >= {1'b0, dvs};
	assign diff = t - {1'b0, dvs};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[M-1:0] : t[M-1:0];
			low_s1 <= {low_i[22:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	assign vld_o = vld_s1;
	assign rem_o = rem_s1;
	assign low_o = low_s1;

endmodule

FILE: src/fbm_value_noise_height.sv
// throughput: one item per cycle while the output is not stalled, set by the fully
// pipelined octave and divider chains
// the whole pipeline advances together and stalls only while a height waits at the output
// reset: arst_n clears all valid flags and restores the registers to their reset values
// registers: seed 0, octave count 4, noise scale 1311, height scale 5120; no clearing pass
`timescale 1ns / 1ps
`include "fbm_value_noise_height_defines.svh"
module fbm_value_noise_height #(
	parameter int MAX_OCTAVES = fbmvn_pkg::MAX_OCTAVES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        height,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import fbmvn_pkg::*;

	localparam int M = MAX_OCTAVES;
	localparam int CW = $clog2(M + 1);
	localparam int SW = FBM_W + M;
	localparam int NDIV = FBM_W;

	// configuration registers
	logic [31:0] seed_q;
	logic [3:0]  octaves_q;
	logic [15:0] nscale_q;
	logic [23:0] hscale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
			octaves_q <= 4'd4;
			nscale_q <= 16'd1311;
			hscale_q <= 24'd5120;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEED: seed_q <= cfg_data;
				CFG_OCTAVES: octaves_q <= cfg_data[3:0];
				CFG_NSCALE: nscale_q <= cfg_data[15:0];
				CFG_HSCALE: hscale_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// clamp the octave count to 1..M; weight total is 2^c-1
	logic [CW-1:0] cnt;
	logic [M:0] pow_c;
	logic [M-1:0] dvs;

	always_comb begin
		if (octaves_q == 4'd0) begin
			cnt = CW'(1);
		end else if (32'(octaves_q) > 32'(M)) begin
			cnt = CW'(M);
		end else begin
			cnt = CW'(octaves_q);
		end
		pow_c = (M+1)'(1) << cnt;
		dvs = M'(pow_c - (M+1)'(1));
	end

	// global advance: everything moves unless a result is stuck at the output
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// front stage: world * scale, Q24.24 signed
	logic signed [48:0] px_s1, pz_s1;
	logic vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 49'(world_x) * $signed({33'd0, nscale_q});
			pz_s1 <= 49'(world_z) * $signed({33'd0, nscale_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// floor to Q32.16, sign carried into the upper lattice bits
	lat_t lat_c [M+1];
	logic [SW-1:0] acc_c [M+1];
	logic vld_c [M+1];

	assign lat_c[0].bx = {{7{px_s1[48]}}, px_s1[48:8]};
	assign lat_c[0].bz = {{7{pz_s1[48]}}, pz_s1[48:8]};
	assign acc_c[0] = '0;
	assign vld_c[0] = vld_s1;

	// octave chain, cell i works at lattice doubling i
	for (genvar i = 0; i < M; i++) begin : g_oct
		fbmvn_octave_cell #(
			.IDX(i),
			.CW(CW),
			.SW(SW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.seed(seed_q),
			.cnt(cnt),
			.vld_i(vld_c[i]),
			.lat_i(lat_c[i]),
			.acc_i(acc_c[i]),
			.vld_o(vld_c[i+1]),
			.lat_o(lat_c[i+1]),
			.acc_o(acc_c[i+1])
		);
	end

	// divider chain, one quotient bit per cell
	logic [M-1:0] rem_c [NDIV+1];
	logic [23:0] low_c [NDIV+1];
	logic dv_c [NDIV+1];

	assign rem_c[0] = acc_c[M][SW-1:FBM_W];
	assign low_c[0] = acc_c[M][FBM_W-1:0];
	assign dv_c[0] = vld_c[M];

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		fbmvn_div_cell #(
			.M(M)
		) u_div (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.dvs(dvs),
			.vld_i(dv_c[k]),
			.rem_i(rem_c[k]),
			.low_i(low_c[k]),
			.vld_o(dv_c[k+1]),
			.rem_o(rem_c[k+1]),
			.low_o(low_c[k+1])
		);
	end

	// height multiply then output register
	logic [47:0] hm_s1;
	logic vld_m_s1;
	logic [23:0] height_q;
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (en) begin
			hm_s1 <= low_c[NDIV] * hscale_q;
			// fbm is below one, so the product never passes the height range
			height_q <= hm_s1[47:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_m_s1 <= dv_c[NDIV];
			out_valid_q <= vld_m_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign height = height_q;

	`FBMVN_ASSERT(a_acc_bound, clk, arst_n, vld_c[M] |-> (acc_c[M][SW-1:FBM_W] < dvs), "octave sum exceeds weight total")
	`FBMVN_ASSERT(a_rem_bound, clk, arst_n, dv_c[NDIV] |-> (rem_c[NDIV] < dvs), "division remainder not below divisor")
	`FBMVN_ASSERT(a_out_load, clk, arst_n, (vld_m_s1 && en) |=> out_valid, "finished height lost before output")

endmodule

FILE: dv/fbm_value_noise_height_tb.sv
// self-checking testbench for the fractal value-noise height block
`timescale 1ns / 1ps
module fbm_value_noise_height_tb;
	import fbmvn_pkg::*;

	localparam int OCT_MAX = 8;
	localparam int LATENCY = 4 * OCT_MAX + 27;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] world_x = '0;
	logic signed [31:0] world_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [23:0] height;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// shadow copy of the registers
	logic [31:0] sh_seed;
	logic [3:0] sh_octaves;
	logic [15:0] sh_nscale;
	logic [23:0] sh_hscale;

	logic [23:0] height_queue[$];
	int errors = 0;
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	bit burst_mode = 1'b1;

	fbm_value_noise_height dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// lattice hash of one corner
	function automatic logic [31:0] corner_hash(logic [31:0] xi, logic [31:0] zi,
			logic [31:0] seed);
		logic [31:0] n;
		n = xi * HASH_X + zi * HASH_Z + seed;
		n = (n ^ (n >> 13)) * HASH_MIX;
		n = n ^ (n >> 16);
		return n & VALUE_MASK;
	endfunction

	function automatic logic [63:0] smooth16(logic [63:0] t);
		return (t * t * (64'd196608 - 2 * t)) >> 32;
	endfunction

	function automatic logic [63:0] mix16(logic [63:0] p, logic [63:0] q, logic [63:0] w);
		return (p * (64'd65536 - w) + q * w) >> 16;
	endfunction

	// world Q24.8 times noise scale, floored to Q32.16 (sign-extended 64 bit)
	function automatic logic [63:0] lattice_of(logic signed [31:0] w);
		logic signed [63:0] p;
		p = 64'(w) * $signed({48'd0, sh_nscale});
		return 64'(p >>> 8);
	endfunction

	function automatic logic [23:0] predict_height(logic signed [31:0] wx,
			logic signed [31:0] wz);
		logic [63:0] bx, bz, cx, cz, acc, total, fbm, h, u, v;
		logic [63:0] ca, cb, cc, cd;
		logic [31:0] xi, zi, seed;
		int cnt;
		bx = lattice_of(wx);
		bz = lattice_of(wz);
		cnt = sh_octaves;
		if (cnt < 1) cnt = 1;
		if (cnt > OCT_MAX) cnt = OCT_MAX;
		acc = 0;
		total = 0;
		for (int i = 0; i < cnt; i++) begin
			cx = bx << i;
			cz = bz << i;
			xi = cx[47:16];
			zi = cz[47:16];
			seed = sh_seed + 32'(i);
			u = smooth16({48'd0, cx[15:0]});
			v = smooth16({48'd0, cz[15:0]});
			ca = corner_hash(xi, zi, seed);
			cb = corner_hash(xi + 1, zi, seed);
			cc = corner_hash(xi, zi + 1, seed);
			cd = corner_hash(xi + 1, zi + 1, seed);
			acc += mix16(mix16(ca, cb, u), mix16(cc, cd, u), v) << (OCT_MAX - 1 - i);
			total += 64'd1 << (OCT_MAX - 1 - i);
		end
		fbm = acc / total;
		h = (fbm * sh_hscale) >> 24;
		if (h > 64'hFFFFFF) h = 64'hFFFFFF;
		return h[23:0];
	endfunction

	// receiver: random stall pattern, occasional long hold-off
	always @(posedge clk) begin
		if (long_hold) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
	end

	// checker: compares each accepted height with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (height_queue.size() == 0) begin
				$display("%0t unexpected height %h", $time, height);
				errors++;
			end else begin
				logic [23:0] exp_h;
				exp_h = height_queue.pop_front();
				if (exp_h !== height) begin
					$display("%0t height mismatch expected %h actual %h", $time, exp_h, height);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[fbm_value_noise_height] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SEED: sh_seed = val;
			CFG_OCTAVES: sh_octaves = val[3:0];
			CFG_NSCALE: sh_nscale = val[15:0];
			CFG_HSCALE: sh_hscale = val[23:0];
			default: ;
		endcase
	endtask

	// sends one item; random gap between bursts, valid stays up inside a burst
	task automatic send_coord(logic signed [31:0] x, logic signed [31:0] z);
		if (burst_mode && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		world_x <= x;
		world_z <= z;
		height_queue = {height_queue, predict_height(x, z)};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (height_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
			default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
		endcase
	endfunction

	task automatic test_reset_defaults;
		send_coord(32'sd0, 32'sd0);
		send_coord(32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_coord(-32'sh80000000, -32'sh80000000);
		send_coord(32'sh7FFFFFFF, -32'sh80000000);
		send_coord(-32'sd1, 32'sd1);
		drain();
	endtask

	task automatic test_register_extremes;
		write_reg(CFG_OCTAVES, 32'd0);       // zero count acts as one octave
		write_reg(CFG_SEED, 32'hFFFFFFFF);
		write_reg(CFG_NSCALE, 32'hFFFF);
		write_reg(CFG_HSCALE, 32'hFFFFFF);   // full-scale height
		send_coord(32'sh7FFFFFFF, 32'sd0);
		send_coord(-32'sh80000000, 32'sh7FFFFFFF);
		send_coord(32'sh12345678, -32'sd300);
		drain();
		write_reg(CFG_OCTAVES, 32'd15);      // clipped to max octaves
		write_reg(CFG_NSCALE, 32'd0);
		write_reg(CFG_HSCALE, 32'd0);
		send_coord(32'sh7FFFFFFF, 32'sh7FFFFFFF);
		drain();
		write_reg(CFG_NSCALE, 32'hFFFF);
		write_reg(CFG_HSCALE, 32'hFFFFFF);
		write_reg(3'd6, 32'hDEADBEEF);       // out-of-range index is ignored
		send_coord(32'sh7FFFFFFF, -32'sh80000000);
		send_coord(32'sh00FF_FF80, 32'sh0000_0080);
		send_coord(-32'sh00000100, 32'sh55555555);
		drain();
		write_reg(CFG_OCTAVES, 32'd1);
		write_reg(CFG_SEED, 32'd0);
		send_coord(32'sh000000FF, 32'shFFFFFF01);
		drain();
	endtask

	task automatic test_backpressure;
		// receiver holds off long enough for the pipeline to fill
		fork
			begin
				long_hold = 1'b1;
				repeat (LATENCY * 3) @(posedge clk);
				long_hold = 1'b0;
			end
			begin
				burst_mode = 1'b0;
				repeat (LATENCY * 2) send_coord(rand_coord(), rand_coord());
				burst_mode = 1'b1;
			end
		join
		drain();
	endtask

	task automatic test_random_phases;
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_SEED, $urandom);
			write_reg(CFG_OCTAVES, (ph == 0) ? 32'd8 : $urandom_range(0, 15));
			write_reg(CFG_NSCALE, (ph == 1) ? 32'hFFFF : $urandom_range(0, 65535));
			write_reg(CFG_HSCALE, (ph % 3 == 0) ? $urandom_range(0, 24'hFFFFFF)
					: $urandom_range(0, 16'hFFFF));
			burst_mode = (ph % 4 != 3);    // some phases stream with no gaps
			repeat (100) send_coord(rand_coord(), rand_coord());
			drain();
		end
	endtask

	initial begin
		sh_seed = 32'd0;
		sh_octaves = 4'd4;
		sh_nscale = 16'd1311;
		sh_hscale = 24'd5120;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_backpressure();
		test_random_phases();
		if (errors == 0 && height_queue.size() == 0) begin
			$display("[fbm_value_noise_height] OK");
		end else begin
			$display("[fbm_value_noise_height] ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/fbmvn_pkg.sv
src/fbmvn_octave_cell.sv
src/fbmvn_div_cell.sv
src/fbm_value_noise_height.sv
dv/fbm_value_noise_height_tb.sv
